// ===== hw/rtl/pob_pkg.sv =====
// Package: shared constants, payload structs and control types for the order book.
`timescale 1ns / 1ps
package pob_pkg;

  localparam int unsigned BOOK_DEPTH = 128;
  localparam int unsigned ADDR_W     = $clog2(BOOK_DEPTH);
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned PRICE_W    = 32;
  localparam int unsigned QTY_W      = 32;
  localparam int unsigned ENTRY_W    = PRICE_W + QTY_W;

  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_MODIFY = 3'd1;
  localparam logic [2:0] ACT_DELETE = 3'd2;
  localparam logic [2:0] ACT_READ   = 3'd3;

  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_RANGE   = 3'd1;
  localparam logic [2:0] STAT_FULL    = 3'd2;
  localparam logic [2:0] STAT_NOENTRY = 3'd3;
  localparam logic [2:0] STAT_BADACT  = 3'd4;

  typedef struct packed {
    logic        [2:0]         action;
    logic        [7:0]         position;
    logic        [PRICE_W-1:0] price;
    logic signed [QTY_W-1:0]   quantity;
  } req_t;

  typedef struct packed {
    logic        [2:0]         status;
    logic        [CNT_W-1:0]   book_size;
    logic        [PRICE_W-1:0] entry_price;
    logic signed [QTY_W-1:0]   entry_quantity;
  } resp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_DROP,
    S_FETCH,
    S_COMMIT,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    WR_SHIFT,
    WR_NEW,
    WR_MERGE
  } wr_mode_e;

  // datapath -> sequencer
  typedef struct packed {
    logic fail;
    logic act_ins;
    logic act_mod;
    logic act_del;
    logic act_rd;
    logic ins_direct;
    logic del_direct;
    logic sh_done;
    logic shift_up;
  } flags_t;

  // sequencer -> datapath
  typedef struct packed {
    logic     req_ld;
    logic     dec;
    logic     rd_en;
    logic     rd_shift;
    logic     wr_en;
    wr_mode_e wr_mode;
    logic     idx_step;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     cap_rd;
    logic     done;
    logic     busy;
  } ctrl_t;

endpackage

// ===== hw/rtl/pob_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pob_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/pob_ctrl.sv =====
// Sequencer: walks each request through decode, any entry shifting or fetch and commit, and response.
`timescale 1ns / 1ps
module pob_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  pob_pkg::flags_t flags_i,
  output pob_pkg::ctrl_t  ctrl_o
);
  import pob_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (flags_i.fail) begin
          state_d = S_RESP;
        end else if (flags_i.act_ins) begin
          state_d = flags_i.ins_direct ? S_PUT : S_SH_RD;
        end else if (flags_i.act_del) begin
          state_d = flags_i.del_direct ? S_DROP : S_SH_RD;
        end else begin
          state_d = S_FETCH;
        end
      end
      S_SH_RD: state_d = S_SH_WR;
      S_SH_WR: begin
        if (flags_i.sh_done) begin
          state_d = flags_i.shift_up ? S_PUT : S_DROP;
        end else begin
          state_d = S_SH_RD;
        end
      end
      S_PUT:    state_d = S_RESP;
      S_DROP:   state_d = S_RESP;
      S_FETCH:  state_d = S_COMMIT;
      S_COMMIT: state_d = S_RESP;
      S_RESP:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.wr_mode  = WR_SHIFT;
    ctrl_o.busy     = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: ctrl_o.req_ld = start_i;
      S_DECODE: ctrl_o.dec = 1'b1;
      S_SH_RD: begin
        ctrl_o.rd_en    = 1'b1;
        ctrl_o.rd_shift = 1'b1;
      end
      S_SH_WR: begin
        ctrl_o.wr_en    = 1'b1;
        ctrl_o.wr_mode  = WR_SHIFT;
        ctrl_o.idx_step = 1'b1;
      end
      S_PUT: begin
        ctrl_o.wr_en   = 1'b1;
        ctrl_o.wr_mode = WR_NEW;
        ctrl_o.cnt_inc = 1'b1;
      end
      S_DROP: ctrl_o.cnt_dec = 1'b1;
      S_FETCH: ctrl_o.rd_en = 1'b1;
      S_COMMIT: begin
        ctrl_o.wr_en   = flags_i.act_mod;
        ctrl_o.wr_mode = WR_MERGE;
        ctrl_o.cap_rd  = flags_i.act_rd;
      end
      S_RESP: ctrl_o.done = 1'b1;
      default: ctrl_o.busy = 1'b1;
    endcase
  end

endmodule

// ===== hw/rtl/positional_order_book.sv =====
// Top level: positional order book with request decode, index unit and entry RAM.
// From accept to done_o: an error goes from decode straight to the response;
// read or modify passes through fetch and commit; insert or delete moves the entries
// past the position (one RAM read and one RAM write per entry through the single port pair).
// Throughput: one request at a time; start is taken again the cycle after done_o.
// Reset clears the sequencer and the entry count; the entry RAM is not cleared.
// done_o is a one-cycle strobe and cannot be stalled; resp_o holds until the next request.
`timescale 1ns / 1ps
module positional_order_book (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  pob_pkg::req_t  req_i,
  output logic           busy,
  output logic           done_o,
  output pob_pkg::resp_t resp_o
);
  import pob_pkg::*;

  ctrl_t ctrl;
  flags_t flags;

  req_t               req_q;
  logic [CNT_W-1:0]   count_q;
  logic [ADDR_W-1:0]  idx_q, idx_d;
  logic [2:0]         status_q, status_d;
  logic [PRICE_W-1:0] rd_price_q;
  logic [QTY_W-1:0]   rd_qty_q;

  logic [CNT_W-1:0]   pos_m1_full;
  logic [ADDR_W-1:0]  pos_m1;
  logic [ADDR_W-1:0]  idx_up, idx_dn;
  logic [CNT_W:0]     pos_ext, cnt_p1, idx_p2;
  logic               range_bad, full, noent;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [PRICE_W-1:0] old_price, mrg_price;
  logic [QTY_W-1:0]   old_qty, mrg_qty;

  assign pos_m1_full = req_q.position - CNT_W'(1);
  assign pos_m1      = pos_m1_full[ADDR_W-1:0];
  assign idx_up      = idx_q + ADDR_W'(1);
  assign idx_dn      = idx_q - ADDR_W'(1);
  assign pos_ext     = {1'b0, req_q.position};
  assign cnt_p1      = {1'b0, count_q} + (CNT_W+1)'(1);
  assign idx_p2      = (CNT_W+1)'(idx_q) + (CNT_W+1)'(2);

  assign range_bad = (req_q.position == '0) || (pos_ext > cnt_p1);
  assign full      = (count_q >= CNT_W'(BOOK_DEPTH));
  assign noent     = (req_q.position > count_q);

  always_comb begin
    if (range_bad) begin
      status_d = STAT_RANGE;
    end else begin
      case (req_q.action) inside
        ACT_INSERT:                       status_d = full ? STAT_FULL : STAT_OK;
        ACT_MODIFY, ACT_DELETE, ACT_READ: status_d = noent ? STAT_NOENTRY : STAT_OK;
        default:                          status_d = STAT_BADACT;
      endcase
    end
  end

  assign flags.fail       = (status_d != STAT_OK);
  assign flags.act_ins    = (req_q.action == ACT_INSERT);
  assign flags.act_mod    = (req_q.action == ACT_MODIFY);
  assign flags.act_del    = (req_q.action == ACT_DELETE);
  assign flags.act_rd     = (req_q.action == ACT_READ);
  assign flags.ins_direct = (count_q == pos_m1_full);
  assign flags.del_direct = (req_q.position == count_q);
  assign flags.shift_up   = (req_q.action == ACT_INSERT);
  assign flags.sh_done    = flags.shift_up ? (idx_dn == pos_m1)
                                           : (idx_p2 >= {1'b0, count_q});

  always_comb begin
    idx_d = idx_q;
    if (ctrl.dec) begin
      idx_d = flags.shift_up ? count_q[ADDR_W-1:0] : pos_m1;
    end else if (ctrl.idx_step) begin
      idx_d = flags.shift_up ? idx_dn : idx_up;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl.cnt_inc) begin
      count_q <= count_q + CNT_W'(1);
    end else if (ctrl.cnt_dec) begin
      count_q <= count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.req_ld) req_q <= req_i;
    idx_q <= idx_d;
    if (ctrl.dec) begin
      status_q   <= status_d;
      rd_price_q <= '0;
      rd_qty_q   <= '0;
    end else if (ctrl.cap_rd) begin
      rd_price_q <= old_price;
      rd_qty_q   <= old_qty;
    end
  end

  assign old_price = ram_rdata[ENTRY_W-1:QTY_W];
  assign old_qty   = ram_rdata[QTY_W-1:0];
  assign mrg_price = (req_q.price != '0) ? req_q.price : old_price;
  assign mrg_qty   = (req_q.quantity != '0) ? req_q.quantity : old_qty;

  assign ram_raddr = ctrl.rd_shift ? (flags.shift_up ? idx_dn : idx_up) : pos_m1;
  assign ram_we    = ctrl.wr_en;

  always_comb begin
    case (ctrl.wr_mode)
      WR_SHIFT: begin
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
      end
      WR_NEW: begin
        ram_waddr = pos_m1;
        ram_wdata = {req_q.price, req_q.quantity};
      end
      WR_MERGE: begin
        ram_waddr = pos_m1;
        ram_wdata = {mrg_price, mrg_qty};
      end
      default: begin
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
      end
    endcase
  end

  pob_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(BOOK_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ctrl.rd_en),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  pob_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .flags_i(flags),
    .ctrl_o (ctrl)
  );

  assign busy                  = ctrl.busy;
  assign done_o                = ctrl.done;
  assign resp_o.status         = status_q;
  assign resp_o.book_size      = count_q;
  assign resp_o.entry_price    = rd_price_q;
  assign resp_o.entry_quantity = rd_qty_q;

endmodule
